[hw/rtl/bmpw_pkg.sv]
// Shared types, constants and the header byte table for the BMP writer.
// No dependencies; every other file in hw/rtl uses it by scoped names.
`default_nettype none

package bmpw_pkg;

   localparam int DIM_W     = 13;
   localparam int SRC_W     = 5;
   localparam int BI_W      = 4;
   localparam int OFF_W     = 27;
   localparam int ROW_W     = 15;
   localparam int PROD_W    = DIM_W + ROW_W;
   localparam int WORD_W    = 32;
   localparam int CNT_W     = 6;
   localparam int HDR_IDX_W = 6;
   localparam int CSR_AW    = 4;

   localparam int DIM_MAX   = (1 << DIM_W) - 1;
   localparam int SRC_MAX   = (1 << SRC_W) - 1;

   localparam int HDR_BYTES  = 54;
   localparam int INFO_BYTES = 40;
   localparam int BMP_WIDE   = 4;
   localparam int BMP_NARROW = 3;

   localparam logic [15:0]       BMP_MAGIC = 16'h4D42;
   localparam logic [WORD_W-1:0] RES_PPM   = 32'd2835;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_SRC    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic              is_hdr;
      logic [OFF_W-1:0]  off;
      logic [CNT_W-1:0]  cnt;
      logic [7:0]        val;
      logic [7:0]        fill_val;
      logic [1:0]        fill_n;
      logic              done;
   } job_type;

   typedef struct packed {
      logic [WORD_W-1:0] fsize;
      logic [WORD_W-1:0] dsize;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [7:0]        bpp;
   } hdr_type;

   function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                          input hdr_type h);
      logic [HDR_BYTES*8-1:0] v;
      v = '0;
      v[15:0]    = BMP_MAGIC;
      v[47:16]   = h.fsize;
      v[87:80]   = 8'(HDR_BYTES);
      v[119:112] = 8'(INFO_BYTES);
      v[175:144] = {{(WORD_W-DIM_W){1'b0}}, h.width};
      v[207:176] = {{(WORD_W-DIM_W){1'b0}}, h.height};
      v[223:208] = 16'd1;
      v[239:224] = {8'd0, h.bpp};
      v[303:272] = h.dsize;
      v[335:304] = RES_PPM;
      v[367:336] = RES_PPM;
      return v[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bmpw_if.sv]
// Request and response channel interfaces of the BMP writer.
// Depends on bmpw_pkg for field widths.
`default_nettype none

interface bmpw_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] pixel_byte;

   modport source(output valid, action, pixel_byte, input ready);
   modport sink(input valid, action, pixel_byte, output ready);
endinterface

interface bmpw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bmpw_pkg::OFF_W-1:0] byte_offset;
   logic [7:0]                 byte_value;
   logic                       last_of_run;
   logic                       frame_done;

   modport source(output valid, byte_offset, byte_value, last_of_run, frame_done,
                  input ready);
   modport sink(input valid, byte_offset, byte_value, last_of_run, frame_done,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/bmpw_emitter.sv]
// Result sequencer: holds one job (header or pixel run) and emits one file byte
// per cycle into the response register unless stalled. Uses bmpw_pkg and bmpw_rsp_if.
`default_nettype none

module bmpw_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  bmpw_pkg::job_type job,
   input  bmpw_pkg::hdr_type hdr,
   output logic              can_load,
   bmpw_rsp_if.source        rsp
);

   bmpw_pkg::job_type job_ff, job_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bmpw_pkg::OFF_W-1:0]  rsp_off_ff;
   logic [7:0]                  rsp_val_ff;
   logic                        rsp_last_ff, rsp_done_ff;
   logic                        out_free, emit, last_one;
   logic [7:0]                  cur_val;

   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      emit     = (job_ff.cnt != '0) && out_free;
      last_one = job_ff.cnt == bmpw_pkg::CNT_W'(1);
      can_load = (job_ff.cnt == '0) || (last_one && out_free);
      cur_val  = job_ff.is_hdr
               ? bmpw_pkg::hdr_byte(job_ff.off[bmpw_pkg::HDR_IDX_W-1:0], hdr)
               : job_ff.val;

      job_in = job_ff;
      if (load) begin
         job_in = job;
      end else if (emit) begin
         job_in.off = job_ff.off + bmpw_pkg::OFF_W'(1);
         job_in.cnt = job_ff.cnt - bmpw_pkg::CNT_W'(1);
         if (job_ff.fill_n != 2'd0) begin
            job_in.val    = job_ff.fill_val;
            job_in.fill_n = job_ff.fill_n - 2'd1;
         end else begin
            job_in.val = 8'd0;
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_off_ff  <= job_ff.off;
         rsp_val_ff  <= cur_val;
         rsp_last_ff <= last_one;
         rsp_done_ff <= last_one && job_ff.done;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.byte_offset = rsp_off_ff;
   assign rsp.byte_value  = rsp_val_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.frame_done  = rsp_done_ff;

endmodule

`default_nettype wire

[hw/rtl/raw_pixels_to_bmp_writer_top.sv]
// Top level of the raw pixel stream to BMP file writer: CSRs, frame geometry,
// pixel placement. Uses bmpw_pkg, bmpw_req_if/bmpw_rsp_if and bmpw_emitter.
//
// A start request emits the 54-byte BMP header; each pixel byte request then
// emits its file byte(s) as (offset, value) pairs. Results leave one byte per
// cycle while the response channel is not stalled, through a single response
// register, and a new request is taken in the cycle its predecessor's last
// result moves into that register. A request has 1 result for a plain pixel
// byte, up to 6 for a byte that finishes a short pixel at the end of a row
// (fill copies plus row padding), none for a dropped byte or a byte outside a
// frame, and 54 for a start.
// Geometry registers are sampled at start; writes during a frame apply to the
// next one.
`default_nettype none

module raw_pixels_to_bmp_writer_top #(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_HEIGHT    = 4096,
   parameter int MAX_SRC_BYTES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   bmpw_req_if.sink                    req_chan,
   bmpw_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bmpw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int DW = bmpw_pkg::DIM_W;
   localparam int SW = bmpw_pkg::SRC_W;
   localparam int OW = bmpw_pkg::OFF_W;
   localparam int RW = bmpw_pkg::ROW_W;
   localparam int PW = bmpw_pkg::PROD_W;
   localparam int WW = bmpw_pkg::WORD_W;

   localparam int W_CAP_I = (MAX_WIDTH > bmpw_pkg::DIM_MAX) ? bmpw_pkg::DIM_MAX : MAX_WIDTH;
   localparam int H_CAP_I = (MAX_HEIGHT > bmpw_pkg::DIM_MAX) ? bmpw_pkg::DIM_MAX : MAX_HEIGHT;
   localparam int S_CAP_I = (MAX_SRC_BYTES > bmpw_pkg::SRC_MAX) ? bmpw_pkg::SRC_MAX
                                                                : MAX_SRC_BYTES;
   localparam logic [DW-1:0] W_CAP = DW'(W_CAP_I);
   localparam logic [DW-1:0] H_CAP = DW'(H_CAP_I);
   localparam logic [SW-1:0] S_CAP = SW'(S_CAP_I);

   // CSRs
   logic [DW-1:0] cfg_width_ff, cfg_height_ff;
   logic [SW-1:0] cfg_src_ff;
   logic          csr_wr;

   // latched frame geometry
   logic [DW-1:0] w_lat_ff, ht_lat_ff;
   logic [SW-1:0] s_lat_ff;
   logic          b4_lat_ff;
   logic [RW-1:0] wb_lat_ff, pitch_lat_ff;
   logic [1:0]    pad_lat_ff;
   logic [PW-1:0] mult_ff;
   logic [WW-1:0] dsize_ff, fsize_ff;
   logic [1:0]    init_ff;

   // frame walk state
   logic [OW-1:0]               rb_ff, rb_in;
   logic [DW-1:0]               col_ff, col_in, rows_ff, rows_in;
   logic [bmpw_pkg::BI_W-1:0]   bip_ff, bip_in;
   logic [7:0]                  first_ff, first_in;
   logic                        active_ff, active_in;

   // start-time geometry
   logic [DW-1:0] w_use, h_use;
   logic [SW-1:0] s_use;
   logic          b4_use;
   logic [RW-1:0] wb_use, wb_rnd, pitch_use;

   // per-byte placement
   logic [2:0]    b_lat;
   logic [SW-1:0] bi1;
   logic          main_emit, last_b, src_short, row_end, final_pix, done;
   logic [1:0]    fill_n, pad_n;
   logic [DW-1:0] col1, rows_dec;
   logic [RW-1:0] colb;
   logic [OW-1:0] pix, start_off;
   logic [2:0]    n_res, usable;
   logic [7:0]    fill_val;

   logic req_acc, start_acc, byte_acc, load, can_load;
   bmpw_pkg::job_type job;
   bmpw_pkg::hdr_type hdr;

   // ---------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         bmpw_pkg::REG_WIDTH:  csr_prdata = {{(32-DW){1'b0}}, cfg_width_ff};
         bmpw_pkg::REG_HEIGHT: csr_prdata = {{(32-DW){1'b0}}, cfg_height_ff};
         bmpw_pkg::REG_SRC:    csr_prdata = {{(32-SW){1'b0}}, cfg_src_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DW'(1);
         cfg_height_ff <= DW'(1);
         cfg_src_ff    <= SW'(bmpw_pkg::BMP_WIDE);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            bmpw_pkg::REG_WIDTH:  cfg_width_ff  <= csr_pwdata[DW-1:0];
            bmpw_pkg::REG_HEIGHT: cfg_height_ff <= csr_pwdata[DW-1:0];
            bmpw_pkg::REG_SRC:    cfg_src_ff    <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- geometry at start
   always_comb begin
      w_use = (cfg_width_ff == '0) ? DW'(1) : ((cfg_width_ff > W_CAP) ? W_CAP : cfg_width_ff);
      h_use = (cfg_height_ff == '0) ? DW'(1)
            : ((cfg_height_ff > H_CAP) ? H_CAP : cfg_height_ff);
      s_use = (cfg_src_ff == '0) ? SW'(1) : ((cfg_src_ff > S_CAP) ? S_CAP : cfg_src_ff);
      b4_use = s_use >= SW'(bmpw_pkg::BMP_WIDE);
      wb_use = b4_use ? {w_use, 2'b00} : ({2'b00, w_use} + {1'b0, w_use, 1'b0});
      wb_rnd = wb_use + RW'(3);
      pitch_use = {wb_rnd[RW-1:2], 2'b00};
   end

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign start_acc = req_acc && (req_chan.action == bmpw_pkg::ACT_START);
   assign byte_acc  = req_acc && (req_chan.action == bmpw_pkg::ACT_BYTE) && active_ff;

   always_ff @(posedge clock) begin
      if (start_acc) begin
         w_lat_ff     <= w_use;
         ht_lat_ff    <= h_use;
         s_lat_ff     <= s_use;
         b4_lat_ff    <= b4_use;
         wb_lat_ff    <= wb_use;
         pitch_lat_ff <= pitch_use;
         pad_lat_ff   <= 2'(pitch_use - wb_use);
      end
      mult_ff  <= {{RW{1'b0}}, ht_lat_ff - DW'(1)} * {{DW{1'b0}}, pitch_lat_ff};
      dsize_ff <= WW'(mult_ff) + WW'(pitch_lat_ff);
      fsize_ff <= WW'(mult_ff) + WW'(pitch_lat_ff) + WW'(bmpw_pkg::HDR_BYTES);
   end

   // ---------------- placement of one source byte
   always_comb begin
      b_lat     = b4_lat_ff ? 3'(bmpw_pkg::BMP_WIDE) : 3'(bmpw_pkg::BMP_NARROW);
      bi1       = {1'b0, bip_ff} + SW'(1);
      main_emit = {1'b0, bip_ff} < {2'b00, b_lat};
      last_b    = bi1 == s_lat_ff;
      src_short = s_lat_ff < {2'b00, b_lat};
      fill_n    = (last_b && src_short) ? 2'(b_lat - s_lat_ff[2:0]) : 2'd0;
      col1      = col_ff + DW'(1);
      row_end   = last_b && (col1 == w_lat_ff);
      pad_n     = row_end ? pad_lat_ff : 2'd0;
      colb      = b4_lat_ff ? {col_ff, 2'b00} : ({2'b00, col_ff} + {1'b0, col_ff, 1'b0});
      pix       = rb_ff + {{(OW-RW){1'b0}}, colb};
      start_off = main_emit ? pix + {{(OW-bmpw_pkg::BI_W){1'b0}}, bip_ff}
                            : rb_ff + {{(OW-RW){1'b0}}, wb_lat_ff};
      n_res     = {2'b00, main_emit} + {1'b0, fill_n} + {1'b0, pad_n};
      final_pix = (rows_ff == DW'(1)) && (col1 == w_lat_ff);
      usable    = src_short ? s_lat_ff[2:0] : b_lat;
      done      = final_pix && (bi1 == {2'b00, usable});
      fill_val  = (bip_ff == '0) ? req_chan.pixel_byte : first_ff;
      rows_dec  = (rows_ff != '0) ? rows_ff - DW'(1) : rows_ff;
   end

   always_comb begin
      rb_in     = rb_ff;
      col_in    = col_ff;
      rows_in   = rows_ff;
      bip_in    = bip_ff;
      first_in  = first_ff;
      active_in = active_ff;
      if (init_ff[1]) begin
         rb_in = OW'(mult_ff) + OW'(bmpw_pkg::HDR_BYTES);
      end
      if (start_acc) begin
         col_in    = '0;
         rows_in   = h_use;
         bip_in    = '0;
         first_in  = 8'd0;
         active_in = 1'b1;
      end else if (byte_acc) begin
         if (bip_ff == '0) begin
            first_in = req_chan.pixel_byte;
         end
         if (last_b) begin
            bip_in = '0;
            if (row_end) begin
               col_in    = '0;
               rb_in     = rb_ff - {{(OW-RW){1'b0}}, pitch_lat_ff};
               rows_in   = rows_dec;
               active_in = rows_dec != '0;
            end else begin
               col_in = col1;
            end
         end else begin
            bip_in = bi1[bmpw_pkg::BI_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff     <= '0;
         col_ff    <= '0;
         rows_ff   <= '0;
         bip_ff    <= '0;
         first_ff  <= 8'd0;
         active_ff <= 1'b0;
         init_ff   <= 2'b00;
      end else begin
         rb_ff     <= rb_in;
         col_ff    <= col_in;
         rows_ff   <= rows_in;
         bip_ff    <= bip_in;
         first_ff  <= first_in;
         active_ff <= active_in;
         init_ff   <= {init_ff[0], start_acc};
      end
   end

   // ---------------- job to the emitter
   always_comb begin
      load = start_acc || (byte_acc && (n_res != 3'd0));
      if (start_acc) begin
         job.is_hdr   = 1'b1;
         job.off      = '0;
         job.cnt      = bmpw_pkg::CNT_W'(bmpw_pkg::HDR_BYTES);
         job.val      = 8'd0;
         job.fill_val = 8'd0;
         job.fill_n   = 2'd0;
         job.done     = 1'b0;
      end else begin
         job.is_hdr   = 1'b0;
         job.off      = start_off;
         job.cnt      = bmpw_pkg::CNT_W'(n_res);
         job.val      = req_chan.pixel_byte;
         job.fill_val = fill_val;
         job.fill_n   = fill_n;
         job.done     = done;
      end
      hdr.fsize  = fsize_ff;
      hdr.dsize  = dsize_ff;
      hdr.width  = w_lat_ff;
      hdr.height = ht_lat_ff;
      hdr.bpp    = b4_lat_ff ? 8'(bmpw_pkg::BMP_WIDE * 8) : 8'(bmpw_pkg::BMP_NARROW * 8);
   end

   assign req_chan.ready = can_load;

   bmpw_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .job      (job),
      .hdr      (hdr),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

   // ---------------- assertions
   a_active_rows: assert property (@(posedge clock) disable iff (reset)
      active_ff == (rows_ff != '0))
      else $error("frame active flag out of step with row count");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (col_ff < w_lat_ff))
      else $error("pixel column beyond image width");

   a_bip_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ({1'b0, bip_ff} < s_lat_ff))
      else $error("byte position beyond source pixel size");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_done) |-> rsp_chan.last_of_run)
      else $error("frame done on a result that does not end its request");

endmodule

`default_nettype wire
